>>> rtl/ptss_pkg.sv
package ptss_pkg;

  localparam int SLOT_COUNT_DEF = 12;
  localparam int MAX_RESULTS    = 12;
  localparam int HIT_W          = $clog2(MAX_RESULTS + 1);
  localparam int TICK_W         = 32;
  localparam int SLOT_W         = 4;
  localparam int RANGE_W        = 7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUE    = 2'd1,
    ST_GRANT  = 2'd2,
    ST_NOFREE = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [TICK_W-1:0]   period_ticks;
    logic                active_flag;
    logic                immediate;
    logic [SLOT_W-1:0]   slot_index;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_number;
    logic [TICK_W-1:0]   clock_now;
    logic                last;
  } rsp_t;

endpackage

>>> rtl/periodic_task_slot_scheduler.sv
// Channel | Handshake              | Payload          | Meaning
// cmd     | cmd_valid / cmd_stall  | ptss_pkg::cmd_t  | tick, scan, allocate, set active
// rsp     | rsp_valid / rsp_stall  | ptss_pkg::rsp_t  | one or more results per command
//
// Allocate walks up from slot 0 to the lowest free slot, or through all slots when none is free;
// scan walks the slots in turn, reading the period/due RAMs for each slot before checking it.
// One shared 32-bit adder serves all commands and one due compare serves the scan; one command at a time.
// Reset is synchronous: counter to zero, every slot free, no result pending.
// A stalled rsp holds the scan loop on the next due slot until the output register drains.
module periodic_task_slot_scheduler #(
  parameter int SLOT_COUNT = ptss_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  ptss_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ptss_pkg::rsp_t rsp
);

  import ptss_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ALLOC,
    S_SET_RD,
    S_SET_UPD,
    S_EMIT
  } state_t;

  state_t               state, state_next;
  cmd_t                 item, item_next;
  logic [IW-1:0]        idx, idx_next;
  logic [HIT_W-1:0]     hits, hits_next;
  logic [TICK_W-1:0]    count, count_next;
  status_t              res_status, res_status_next;
  logic [SLOT_W-1:0]    res_slot, res_slot_next;
  logic                 in_range, in_range_next;
  logic [SLOT_COUNT-1:0] slot_free;
  logic [SLOT_COUNT-1:0] slot_active;

  logic                 per_we, due_we, act_we, free_clr;
  logic                 rsp_load, rsp_last, rsp_room, hit;
  logic [TICK_W-1:0]    per_rd, due_rd;
  logic [TICK_W-1:0]    add_a, add_b, sum;

  assign cmd_stall = (state != S_IDLE);
  assign rsp_room  = !rsp_valid || !rsp_stall;

  ptss_ram #(.WIDTH(TICK_W), .DEPTH(SLOT_COUNT)) u_period (
    .clk   (clk),
    .we    (per_we),
    .waddr (idx),
    .wdata (item.period_ticks),
    .raddr (idx),
    .rdata (per_rd)
  );

  ptss_ram #(.WIDTH(TICK_W), .DEPTH(SLOT_COUNT)) u_due (
    .clk   (clk),
    .we    (due_we),
    .waddr (idx),
    .wdata (sum),
    .raddr (idx),
    .rdata (due_rd)
  );

  always_comb begin
    add_a = count;
    add_b = '0;
    case (state)
      S_EXEC: begin
        add_b = TICK_W'(1);
      end
      S_SCAN_CHK: begin
        add_a = due_rd;
        add_b = per_rd;
      end
      S_ALLOC: begin
        add_b = item.immediate ? '0 : item.period_ticks;
      end
      S_SET_UPD: begin
        add_b = item.immediate ? '0 : per_rd;
      end
      default: begin
      end
    endcase
    sum = add_a + add_b;
  end

  assign hit = !slot_free[idx] && slot_active[idx] && (due_rd < count);

  always_comb begin
    state_next      = state;
    item_next       = item;
    idx_next        = idx;
    hits_next       = hits;
    count_next      = count;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    in_range_next   = in_range;
    per_we          = 1'b0;
    due_we          = 1'b0;
    act_we          = 1'b0;
    free_clr        = 1'b0;
    rsp_load        = 1'b0;
    rsp_last        = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          item_next  = cmd;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        idx_next        = '0;
        hits_next       = '0;
        res_status_next = ST_DONE;
        res_slot_next   = '0;
        in_range_next   = RANGE_W'(item.slot_index) < RANGE_W'(SLOT_COUNT);
        case (item.operation)
          OP_TICK: begin
            count_next = sum;
            state_next = S_EMIT;
          end
          OP_SCAN: begin
            state_next = S_SCAN_RD;
          end
          OP_ALLOC: begin
            state_next = S_ALLOC;
          end
          OP_SET: begin
            idx_next   = IW'(item.slot_index);
            state_next = S_SET_RD;
          end
          default: begin
            state_next = S_EMIT;
          end
        endcase
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (hit) begin
          if (res_status != ST_DUE || rsp_room) begin
            rsp_load        = (res_status == ST_DUE);
            rsp_last        = 1'b0;
            due_we          = 1'b1;
            res_status_next = ST_DUE;
            res_slot_next   = SLOT_W'(idx);
            hits_next       = hits + HIT_W'(1);
            if (idx == LAST_IDX || hits == HIT_W'(MAX_RESULTS - 1)) begin
              state_next = S_EMIT;
            end else begin
              idx_next   = idx + IW'(1);
              state_next = S_SCAN_RD;
            end
          end
        end else if (idx == LAST_IDX) begin
          state_next = S_EMIT;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_ALLOC: begin
        if (slot_free[idx]) begin
          per_we          = 1'b1;
          due_we          = 1'b1;
          act_we          = 1'b1;
          free_clr        = 1'b1;
          res_status_next = ST_GRANT;
          res_slot_next   = SLOT_W'(idx);
          state_next      = S_EMIT;
        end else if (idx == LAST_IDX) begin
          res_status_next = ST_NOFREE;
          state_next      = S_EMIT;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_SET_RD: begin
        state_next = S_SET_UPD;
      end
      S_SET_UPD: begin
        if (in_range && !slot_free[idx] && (slot_active[idx] != item.active_flag)) begin
          due_we = 1'b1;
          act_we = 1'b1;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (rsp_room) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      slot_free <= '1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (free_clr) begin
        slot_free[idx] <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp.status      <= res_status;
        rsp.slot_number <= res_slot;
        rsp.clock_now   <= count;
        rsp.last        <= rsp_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    idx        <= idx_next;
    hits       <= hits_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    in_range   <= in_range_next;
    if (act_we) begin
      slot_active[idx] <= item.active_flag;
    end
  end

endmodule

>>> rtl/ptss_ram.sv
module ptss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ptss_checker.sv
module ptss_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ptss_pkg::rsp_t rsp
);

  import ptss_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp changed");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("new cmd taken right after a cmd transaction");

  a_only_due_continues: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_DUE) |-> rsp.last)
    else $error("non-due result not marked last");

  a_no_slot_named: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_DONE || rsp.status == ST_NOFREE)
    |-> rsp.slot_number == '0)
    else $error("slot number set on a result that names no slot");

  a_busy_mid_scan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> cmd_stall)
    else $error("idle while a scan still has results to send");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (.*);
